[hw/rtl/hhd_pkg.sv]
package hhd_pkg;

   localparam int HEADING_W = 12;
   localparam int RANGE_W   = 12;
   localparam int DRIVE_W   = 8;
   localparam int STATUS_W  = 3;
   localparam int TICKS_W   = 16;
   localparam int GAIN_W    = 12;
   localparam int DBAND_W   = 11;
   localparam int LIMIT_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [HEADING_W-1:0] TURN_TENTHS = 12'd3600;
   localparam logic signed [12:0] HALF_TURN   = 13'sd1800;
   localparam logic signed [12:0] FULL_TURN   = 13'sd3600;
   localparam logic signed [8:0]  DRIVE_MAX   = 9'sd100;
   localparam logic [1:0]         NEAR_CONFIRM = 2'd3;
   // floor(x / 5) == (x * 52429) >> 18 for every x below 2^18
   localparam logic [16:0]        RECIP_FIVE  = 17'd52429;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUNNING  = 3'd0,
      ST_TIMEOUT  = 3'd1,
      ST_OBSTACLE = 3'd2,
      ST_ABORTED  = 3'd3,
      ST_IDLE     = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_HEADING   = 3'd0,
      REG_DRIVE_SPEED      = 3'd1,
      REG_RUN_TICKS        = 3'd2,
      REG_OBSTACLE_RANGE   = 3'd3,
      REG_STEER_GAIN       = 3'd4,
      REG_ERROR_DEADBAND   = 3'd5,
      REG_CORRECTION_LIMIT = 3'd6
   } csr_index_type;

endpackage

[hw/rtl/hhd_stream_if.sv]
interface hhd_req_if import hhd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 start_req;
   logic                 cancel;
   logic [HEADING_W-1:0] heading;
   logic                 heading_ok;
   logic [RANGE_W-1:0]   range_a;
   logic                 range_a_ok;
   logic [RANGE_W-1:0]   range_b;
   logic                 range_b_ok;

   modport source (output valid, start_req, cancel, heading, heading_ok,
                   range_a, range_a_ok, range_b, range_b_ok, input ready);
   modport sink   (input valid, start_req, cancel, heading, heading_ok,
                   range_a, range_a_ok, range_b, range_b_ok, output ready);
endinterface

interface hhd_rsp_if import hhd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] right_drive;
   logic signed [DRIVE_W-1:0] left_drive;
   logic [STATUS_W-1:0]       run_status;

   modport source (output valid, right_drive, left_drive, run_status, input ready);
   modport sink   (input valid, right_drive, left_drive, run_status, output ready);
endinterface

[hw/rtl/heading_hold_drive_top.sv]
// Heading hold drive for a two-motor platform.
// req_chan carries one control tick per transfer: start/cancel flags, compass
// heading and two range readings, each with its valid bit. rsp_chan returns
// exactly one result per tick: right and left drive percent and run status.
// Registers are written through csr_we/csr_index/csr_wdata, one per clock;
// write them only while no tick is in flight: the block does not enforce it.
// A tick passes the first stage, then the result register that drives rsp valid.
// One tick is taken per cycle unless the receiver stalls: the first stage forms
// heading error and gain product, the second scales, clamps and updates the run
// state (active, elapsed, near count). When the receiver stalls, the result
// register holds and the first stage fills; req_chan.ready drops only once both
// are occupied. Reset (synchronous, active high) empties the pipeline, ends any
// run and restores register defaults (gain 2.0, deadband 2.0 deg, limit 30 %).
module heading_hold_drive_top import hhd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hhd_req_if.sink               req_chan,
   hhd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [HEADING_W-1:0]      target_heading_ff;
   logic signed [DRIVE_W-1:0] drive_speed_ff;
   logic [TICKS_W-1:0]        run_ticks_ff;
   logic [RANGE_W-1:0]        obstacle_range_ff;
   logic [GAIN_W-1:0]         steer_gain_ff;
   logic [DBAND_W-1:0]        error_deadband_ff;
   logic [LIMIT_W-1:0]        correction_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_heading_ff   <= '0;
         drive_speed_ff      <= '0;
         run_ticks_ff        <= '0;
         obstacle_range_ff   <= '0;
         steer_gain_ff       <= 12'd512;
         error_deadband_ff   <= 11'd20;
         correction_limit_ff <= 7'd30;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET_HEADING:   target_heading_ff   <= csr_wdata[HEADING_W-1:0];
            REG_DRIVE_SPEED:      drive_speed_ff      <= signed'(csr_wdata[DRIVE_W-1:0]);
            REG_RUN_TICKS:        run_ticks_ff        <= csr_wdata[TICKS_W-1:0];
            REG_OBSTACLE_RANGE:   obstacle_range_ff   <= csr_wdata[RANGE_W-1:0];
            REG_STEER_GAIN:       steer_gain_ff       <= csr_wdata[GAIN_W-1:0];
            REG_ERROR_DEADBAND:   error_deadband_ff   <= csr_wdata[DBAND_W-1:0];
            REG_CORRECTION_LIMIT: correction_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_advance, s1_advance, req_xfer;

   assign out_advance = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance  = s1_valid_ff && out_advance;
   assign req_chan.ready = !s1_valid_ff || out_advance;
   assign req_xfer    = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: heading error, gain product, near test
   logic [HEADING_W-1:0] tgt_m, hdg_m;
   logic signed [12:0]   err_raw, err_wrap;
   logic [DBAND_W-1:0]   err_mag;
   logic [22:0]          gain_prod;
   logic [13:0]          range_sum;
   logic                 near_in;

   always_comb begin
      tgt_m = (target_heading_ff >= TURN_TENTHS) ? target_heading_ff - TURN_TENTHS
                                                 : target_heading_ff;
      hdg_m = (req_chan.heading >= TURN_TENTHS) ? req_chan.heading - TURN_TENTHS
                                                : req_chan.heading;
      err_raw = signed'({1'b0, tgt_m}) - signed'({1'b0, hdg_m});
      if (err_raw > HALF_TURN)
         err_wrap = err_raw - FULL_TURN;
      else if (err_raw < -HALF_TURN)
         err_wrap = err_raw + FULL_TURN;
      else
         err_wrap = err_raw;
      err_mag   = err_wrap[12] ? DBAND_W'(-err_wrap) : err_wrap[DBAND_W-1:0];
      gain_prod = {12'd0, err_mag} * {11'd0, steer_gain_ff};

      range_sum = {2'b0, req_chan.range_a} + {2'b0, req_chan.range_b};
      if (req_chan.range_a_ok && req_chan.range_b_ok)
         near_in = range_sum <= {1'b0, obstacle_range_ff, 1'b0};
      else if (req_chan.range_a_ok)
         near_in = req_chan.range_a <= obstacle_range_ff;
      else if (req_chan.range_b_ok)
         near_in = req_chan.range_b <= obstacle_range_ff;
      else
         near_in = 1'b0;
   end

   logic        s1_start_ff, s1_cancel_ff, s1_hok_ff, s1_near_ff;
   logic        s1_neg_ff, s1_dead_ff;
   logic [13:0] s1_prod_ff;   // product / 512

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_start_ff  <= req_chan.start_req;
         s1_cancel_ff <= req_chan.cancel;
         s1_hok_ff    <= req_chan.heading_ok;
         s1_near_ff   <= near_in;
         s1_neg_ff    <= err_wrap[12];
         s1_dead_ff   <= err_mag < error_deadband_ff;
         s1_prod_ff   <= gain_prod[22:9];
      end
   end

   // stage 2: scale, clamp, run state
   logic              active_ff, active_in;
   logic [TICKS_W-1:0] elapsed_ff, elapsed_in;
   logic [1:0]        near_count_ff, near_count_in;
   logic [30:0]       quo_full;
   logic [12:0]       quo;
   logic [LIMIT_W-1:0] corr_mag;
   logic signed [DRIVE_W-1:0] corr;
   logic signed [8:0] right_sum, left_sum;
   logic signed [DRIVE_W-1:0] right_in, left_in;
   logic              run_act;
   logic [TICKS_W-1:0] run_el;
   logic [1:0]        run_nc, nc_inc;
   status_type        status_in;

   function automatic logic signed [DRIVE_W-1:0] clamp_drive(input logic signed [8:0] v);
      if (v > DRIVE_MAX)
         return DRIVE_W'(DRIVE_MAX);
      else if (v < -DRIVE_MAX)
         return DRIVE_W'(-DRIVE_MAX);
      else
         return v[DRIVE_W-1:0];
   endfunction

   always_comb begin
      quo_full = {17'd0, s1_prod_ff} * {14'd0, RECIP_FIVE};
      quo      = quo_full[30:18];
      if (s1_dead_ff)
         corr_mag = '0;
      else if (quo > {6'd0, correction_limit_ff})
         corr_mag = correction_limit_ff;
      else
         corr_mag = quo[LIMIT_W-1:0];
      corr = s1_neg_ff ? -signed'({1'b0, corr_mag}) : signed'({1'b0, corr_mag});
      if (!s1_hok_ff)
         corr = '0;
      right_sum = 9'(drive_speed_ff) + 9'(corr);
      left_sum  = 9'(drive_speed_ff) - 9'(corr);

      run_act = active_ff || s1_start_ff;
      run_el  = s1_start_ff ? '0 : elapsed_ff;
      run_nc  = s1_start_ff ? '0 : near_count_ff;
      nc_inc  = run_nc + 2'd1;

      active_in     = run_act;
      elapsed_in    = run_el;
      near_count_in = run_nc;
      right_in      = '0;
      left_in       = '0;
      status_in     = ST_RUNNING;

      if (!run_act) begin
         status_in = ST_IDLE;
      end else if (run_el >= run_ticks_ff) begin
         active_in = 1'b0;
         status_in = ST_TIMEOUT;
      end else if (s1_cancel_ff) begin
         active_in = 1'b0;
         status_in = ST_ABORTED;
      end else if (obstacle_range_ff != '0 && s1_near_ff && nc_inc == NEAR_CONFIRM) begin
         active_in     = 1'b0;
         near_count_in = '0;
         status_in     = ST_OBSTACLE;
      end else begin
         if (obstacle_range_ff != '0)
            near_count_in = s1_near_ff ? nc_inc : 2'd0;
         if (run_el != '1)
            elapsed_in = run_el + 1'b1;
         right_in = clamp_drive(right_sum);
         left_in  = clamp_drive(left_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         elapsed_ff    <= '0;
         near_count_ff <= '0;
      end else if (s1_advance) begin
         active_ff     <= active_in;
         elapsed_ff    <= elapsed_in;
         near_count_ff <= near_count_in;
      end
   end

   logic signed [DRIVE_W-1:0] right_ff, left_ff;
   status_type                status_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         right_ff  <= right_in;
         left_ff   <= left_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.right_drive = right_ff;
   assign rsp_chan.left_drive  = left_ff;
   assign rsp_chan.run_status  = status_ff;

`ifndef SYNTHESIS
   a_exit_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_RUNNING |-> right_ff == '0 && left_ff == '0)
      else $error("drives not zero outside a run");

   a_running_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_RUNNING |-> active_ff)
      else $error("running result but run state inactive");

   a_exit_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_RUNNING |-> !active_ff)
      else $error("run ended but still active");

   a_near_count_range: assert property (@(posedge clock) disable iff (reset)
      near_count_ff != NEAR_CONFIRM)
      else $error("near count reached confirm value without exit");
`endif

endmodule

[tb/tb_heading_hold_drive_top.sv]
module tb_heading_hold_drive_top;
   import hhd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TENTHS_PER_TURN = 3600;
   localparam int HALF_TURN_TENTHS = 1800;
   localparam int GAIN_DIVISOR = 2560;
   localparam int PERCENT_MAX = 100;
   localparam int OBSTACLE_HITS = 3;
   localparam int ELAPSED_MAX = 65535;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 150;

   typedef struct packed {
      logic                 start_req;
      logic                 cancel;
      logic [HEADING_W-1:0] heading;
      logic                 heading_ok;
      logic [RANGE_W-1:0]   range_a;
      logic                 range_a_ok;
      logic [RANGE_W-1:0]   range_b;
      logic                 range_b_ok;
   } tick_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
      status_type                run_status;
   } drive_result_type;

   typedef struct {
      logic [HEADING_W-1:0]      target_heading;
      logic signed [DRIVE_W-1:0] drive_speed;
      logic [TICKS_W-1:0]        run_ticks;
      logic [RANGE_W-1:0]        obstacle_range;
      logic [GAIN_W-1:0]         steer_gain;
      logic [DBAND_W-1:0]        error_deadband;
      logic [LIMIT_W-1:0]        correction_limit;
   } steer_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hhd_req_if req_bus ();
   hhd_rsp_if rsp_bus ();

   heading_hold_drive_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and run state
   steer_cfg_type cfg;
   bit run_active;
   int run_elapsed;
   int near_run;

   tick_type tick_queue[$];
   drive_result_type drive_expect_q[$];
   bit tick_taken;
   int ticks_queued, ticks_accepted, results_checked, mismatches;
   int runs_started, settings_used;
   int status_seen[8];
   int send_idle_pct, recv_stall_pct;
   int hold_count;
   logic hold_kick;

   function automatic int clip_percent(int v);
      if (v > PERCENT_MAX) return PERCENT_MAX;
      if (v < -PERCENT_MAX) return -PERCENT_MAX;
      return v;
   endfunction

   function automatic drive_result_type predict_drive(tick_type t);
      drive_result_type r;
      bit near;
      int err, mag, corr, lim, spd, tgt, hdg;
      r.right_drive = '0;
      r.left_drive = '0;
      r.run_status = ST_RUNNING;
      if (t.start_req) begin
         run_active = 1'b1;
         run_elapsed = 0;
         near_run = 0;
         runs_started++;
      end
      if (!run_active) begin
         r.run_status = ST_IDLE;
         return r;
      end
      if (run_elapsed >= int'(cfg.run_ticks)) begin
         run_active = 1'b0;
         r.run_status = ST_TIMEOUT;
         return r;
      end
      if (t.cancel) begin
         run_active = 1'b0;
         r.run_status = ST_ABORTED;
         return r;
      end
      if (cfg.obstacle_range != 0) begin
         // two valid readings are judged by their sum against twice the threshold
         if (t.range_a_ok && t.range_b_ok)
            near = int'(t.range_a) + int'(t.range_b) <= 2 * int'(cfg.obstacle_range);
         else if (t.range_a_ok)
            near = t.range_a <= cfg.obstacle_range;
         else if (t.range_b_ok)
            near = t.range_b <= cfg.obstacle_range;
         else
            near = 1'b0;
         if (near) begin
            near_run++;
            if (near_run >= OBSTACLE_HITS) begin
               near_run = 0;
               run_active = 1'b0;
               r.run_status = ST_OBSTACLE;
               return r;
            end
         end else begin
            near_run = 0;
         end
      end
      spd = cfg.drive_speed;
      corr = 0;
      if (t.heading_ok) begin
         tgt = cfg.target_heading;
         hdg = t.heading;
         err = tgt % TENTHS_PER_TURN - hdg % TENTHS_PER_TURN;
         if (err > HALF_TURN_TENTHS) err -= TENTHS_PER_TURN;
         if (err < -HALF_TURN_TENTHS) err += TENTHS_PER_TURN;
         mag = err < 0 ? -err : err;
         if (mag >= int'(cfg.error_deadband)) begin
            corr = mag * int'(cfg.steer_gain) / GAIN_DIVISOR;
            lim = cfg.correction_limit;
            if (corr > lim) corr = lim;
            if (err < 0) corr = -corr;
         end
      end
      if (run_elapsed < ELAPSED_MAX) run_elapsed++;
      r.right_drive = DRIVE_W'(clip_percent(spd + corr));
      r.left_drive = DRIVE_W'(clip_percent(spd - corr));
      return r;
   endfunction

   task automatic check_field(string field, logic signed [8:0] want, logic signed [8:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0d, got %0d", results_checked, field, want, got);
      end
   endtask

   // request driver: a transfer is held until taken
   always @(negedge clock) begin : drive_ticks
      tick_type nt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || tick_taken) begin
         if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nt = tick_queue.pop_front();
            {req_bus.start_req, req_bus.cancel, req_bus.heading, req_bus.heading_ok,
             req_bus.range_a, req_bus.range_a_ok, req_bus.range_b, req_bus.range_b_ok} <= nt;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      tick_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= hold_count == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      if (reset)
         hold_count <= 0;
      else if (hold_kick)
         hold_count <= HOLD_OFF_CYCLES;
      else if (hold_count != 0)
         hold_count <= hold_count - 1;
   end

   always @(posedge clock) begin : watch_transfers
      tick_type seen;
      drive_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen = {req_bus.start_req, req_bus.cancel, req_bus.heading, req_bus.heading_ok,
                    req_bus.range_a, req_bus.range_a_ok, req_bus.range_b, req_bus.range_b_ok};
            drive_expect_q.push_back(predict_drive(seen));
            tick_taken = 1'b1;
            ticks_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing outstanding", results_checked);
            end else begin
               want = drive_expect_q.pop_front();
               check_field("right_drive", want.right_drive, rsp_bus.right_drive);
               check_field("left_drive", want.left_drive, rsp_bus.left_drive);
               check_field("run_status", want.run_status, rsp_bus.run_status);
            end
            status_seen[rsp_bus.run_status]++;
            results_checked++;
         end
      end
   end

   function automatic tick_type make_tick(bit s, bit c, int h, bit hok, int ra, bit aok,
                                          int rb, bit bok);
      tick_type t;
      t.start_req = s;
      t.cancel = c;
      t.heading = HEADING_W'(h);
      t.heading_ok = hok;
      t.range_a = RANGE_W'(ra);
      t.range_a_ok = aok;
      t.range_b = RANGE_W'(rb);
      t.range_b_ok = bok;
      return t;
   endfunction

   function automatic int pick_range();
      int v;
      if ($urandom_range(1)) return $urandom_range(4095);
      // cluster around the obstacle threshold
      v = int'(cfg.obstacle_range) + int'($urandom_range(60)) - 30;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   function automatic tick_type random_tick(bit s);
      int tgt, h;
      tgt = cfg.target_heading % TENTHS_PER_TURN;
      case ($urandom_range(9))
         0: h = 3600 + $urandom_range(495);
         1: h = (tgt + TENTHS_PER_TURN + int'($urandom_range(80)) - 40) % TENTHS_PER_TURN;
         2: h = (tgt + HALF_TURN_TENTHS + TENTHS_PER_TURN + int'($urandom_range(4)) - 2)
                % TENTHS_PER_TURN;
         default: h = $urandom_range(3599);
      endcase
      return make_tick(s, $urandom_range(99) < 2, h, $urandom_range(99) < 85,
                       pick_range(), $urandom_range(3) != 0,
                       pick_range(), $urandom_range(3) != 0);
   endfunction

   function automatic steer_cfg_type random_settings();
      steer_cfg_type c;
      case ($urandom_range(5))
         0: c.target_heading = 0;
         1: c.target_heading = 3599;
         2: c.target_heading = $urandom_range(4095, 3600);
         default: c.target_heading = $urandom_range(3599);
      endcase
      case ($urandom_range(7))
         0: c.drive_speed = -100;
         1: c.drive_speed = 100;
         2: c.drive_speed = -128;
         3: c.drive_speed = 127;
         4: c.drive_speed = 0;
         default: c.drive_speed = DRIVE_W'(int'($urandom_range(200)) - 100);
      endcase
      case ($urandom_range(9))
         0: c.run_ticks = 0;
         1: c.run_ticks = 65535;
         2: c.run_ticks = 1;
         default: c.run_ticks = $urandom_range(40, 2);
      endcase
      case ($urandom_range(5))
         0: c.obstacle_range = 0;
         1: c.obstacle_range = 4000;
         2: c.obstacle_range = 4095;
         default: c.obstacle_range = $urandom_range(1500, 1);
      endcase
      case ($urandom_range(5))
         0: c.steer_gain = 0;
         1: c.steer_gain = 4095;
         2: c.steer_gain = 512;
         default: c.steer_gain = $urandom_range(4095);
      endcase
      case ($urandom_range(5))
         0: c.error_deadband = 0;
         1: c.error_deadband = 1800;
         2: c.error_deadband = 2047;
         default: c.error_deadband = $urandom_range(300);
      endcase
      case ($urandom_range(5))
         0: c.correction_limit = 0;
         1: c.correction_limit = 100;
         2: c.correction_limit = 127;
         default: c.correction_limit = $urandom_range(100);
      endcase
      return c;
   endfunction

   task automatic send_tick(tick_type t);
      tick_queue.push_back(t);
      ticks_queued++;
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
   endtask

   task automatic apply_settings(steer_cfg_type c);
      put_reg(REG_TARGET_HEADING, CSR_DATA_W'(c.target_heading));
      put_reg(REG_DRIVE_SPEED, CSR_DATA_W'(c.drive_speed));
      put_reg(REG_RUN_TICKS, CSR_DATA_W'(c.run_ticks));
      put_reg(REG_OBSTACLE_RANGE, CSR_DATA_W'(c.obstacle_range));
      put_reg(REG_STEER_GAIN, CSR_DATA_W'(c.steer_gain));
      put_reg(REG_ERROR_DEADBAND, CSR_DATA_W'(c.error_deadband));
      put_reg(REG_CORRECTION_LIMIT, CSR_DATA_W'(c.correction_limit));
      @(negedge clock);
      csr_we <= 1'b0;
      cfg = c;
      settings_used++;
   endtask

   // wait until every queued tick has been taken and answered, then let the pipe empty
   task automatic drain();
      while (ticks_accepted != ticks_queued || drive_expect_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
   endtask

   task automatic queue_run_mix(int count);
      int n, len;
      tick_type t;
      n = 0;
      while (n < count) begin
         // stray ticks between runs, with the odd cancel
         repeat ($urandom_range(2)) begin
            send_tick(random_tick(1'b0));
            n++;
         end
         send_tick(random_tick(1'b1));
         n++;
         len = $urandom_range(50, 1);
         repeat (len) begin
            t = random_tick($urandom_range(99) < 3);
            send_tick(t);
            n++;
         end
      end
   endtask

   initial begin : stimulus
      steer_cfg_type c;
      tick_type t;
      req_bus.valid = 1'b0;
      {req_bus.start_req, req_bus.cancel, req_bus.heading, req_bus.heading_ok,
       req_bus.range_a, req_bus.range_a_ok, req_bus.range_b, req_bus.range_b_ok} = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_TARGET_HEADING;
      csr_wdata = '0;
      hold_kick = 1'b0;
      tick_taken = 1'b0;
      set_idling(0);
      cfg = '{0, 0, 0, 0, 512, 20, 30};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrapping, deadband, clamps, near tests and every way a run ends
      apply_settings('{0, 50, 6, 300, 512, 20, 30});
      send_tick(make_tick(0, 1, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(1, 1, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(1, 0, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 3599, 1, 0, 1, 600, 1));
      send_tick(make_tick(0, 0, 1800, 1, 300, 1, 0, 0));
      send_tick(make_tick(0, 0, 1801, 1, 0, 0, 301, 1));
      send_tick(make_tick(0, 0, 4095, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 100, 0, 4095, 1, 4095, 1));
      send_tick(make_tick(0, 0, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(1, 0, 0, 1, 0, 1, 4095, 0));
      send_tick(make_tick(0, 0, 0, 1, 0, 1, 0, 1));
      send_tick(make_tick(0, 0, 0, 1, 4095, 0, 0, 1));
      send_tick(make_tick(1, 0, 3000, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 1, 3000, 1, 0, 0, 0, 0));
      drain();
      apply_settings('{3599, -100, 0, 0, 4095, 0, 100});
      send_tick(make_tick(1, 0, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(1, 1, 0, 1, 0, 0, 0, 0));
      drain();
      apply_settings('{4095, -128, 65535, 4095, 4095, 2047, 127});
      send_tick(make_tick(1, 0, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 2000, 1, 4095, 1, 0, 0));
      send_tick(make_tick(0, 0, 2000, 1, 4095, 1, 4095, 1));
      send_tick(make_tick(0, 0, 2000, 1, 0, 0, 4095, 1));
      drain();
      apply_settings('{0, 127, 5, 0, 4095, 0, 127});
      send_tick(make_tick(1, 0, 1800, 1, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 1, 1, 0, 0, 0, 0));
      drain();

      // a longer run of a hundred ticks, ending in timeout, then one idle tick
      apply_settings('{$urandom_range(3599), 40, 100, 0, 512, 20, 30});
      send_tick(make_tick(1, 0, 0, 1, 0, 0, 0, 0));
      repeat (101) begin
         t = random_tick(1'b0);
         t.cancel = 1'b0;
         send_tick(t);
      end
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         c = random_settings();
         apply_settings(c);
         set_idling(p % 4);
         queue_run_mix(TICKS_PER_PHASE);
         if (p == 0) begin
            // long receiver hold-off while ticks keep coming: input side must back up
            @(negedge clock);
            hold_kick <= 1'b1;
            @(negedge clock);
            hold_kick <= 1'b0;
         end
         drain();
      end

      mismatches += drive_expect_q.size();
      $display("Checked %0d control ticks in %0d runs over %0d register settings.",
               results_checked, runs_started, settings_used);
      $display("Endings: %0d timeout, %0d obstacle, %0d aborted; %0d running, %0d idle ticks.",
               status_seen[ST_TIMEOUT], status_seen[ST_OBSTACLE], status_seen[ST_ABORTED],
               status_seen[ST_RUNNING], status_seen[ST_IDLE]);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/hhd_pkg.sv
hw/rtl/hhd_stream_if.sv
hw/rtl/heading_hold_drive_top.sv
tb/tb_heading_hold_drive_top.sv
